@@ rtl/pcmv_pkg.sv @@
// Shared constants, codes and pipeline structs of the sample voice mixer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pcmv_pkg;

  localparam int unsigned SAMPLE_DEPTH = 4096;
  localparam int unsigned ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned MIX_W        = 24;
  localparam int unsigned POS_W        = 13;
  localparam int unsigned SEEK_W       = 21;
  localparam int unsigned GAIN_W       = 16;
  localparam int unsigned PAN_W        = 17;
  localparam int unsigned CFG_W        = 17;
  localparam int unsigned FRAC_W       = 15;
  localparam int unsigned PROD_W       = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned SCALE_W      = PROD_W - FRAC_W;

  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1 << FRAC_W);
  localparam logic [POS_W-1:0]  DEPTH_CNT = POS_W'(SAMPLE_DEPTH);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_MIX  = 2'd1,
    OP_SEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_COUNT  = 2'd0,
    CFG_STEREO = 2'd1,
    CFG_TRIM   = 2'd2,
    CFG_PAN    = 2'd3
  } cfg_idx_e;

  // count is already clamped to the store depth
  typedef struct packed {
    logic [POS_W-1:0]        count;
    logic                    stereo;
    logic [GAIN_W-1:0]       trim;
    logic signed [PAN_W-1:0] pan;
  } cfg_t;

  // per-item control and pass-through payload, carried down the pipe
  typedef struct packed {
    logic                    active;
    logic                    stereo;
    logic signed [MIX_W-1:0] mix_l;
    logic signed [MIX_W-1:0] mix_r;
    logic [POS_W-1:0]        pos;
    logic                    done;
  } item_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic so;
  } pipe_en_t;

endpackage

`default_nettype wire

@@ rtl/pcm_voice_gain_pan_mixer.sv @@
// One-shot sample voice mixed into a running stereo stream. One item is taken
// every clock cycle while in_stall_o is low, and each gives one result; the
// output register and the stage valids let the pipe keep filling while a
// result waits, so in_stall_o rises only when all four stages hold items
// and out_stall_i is high. The sample store is a 4096 x 16 single-write memory
// read at the playhead in the cycle an item is taken; it needs no clearing
// after reset, but an entry must be loaded before a mix item reads it.
// Configuration writes are always taken (cfg_ready_o is high) and should be
// made only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module pcm_voice_gain_pan_mixer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [pcmv_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          op_i,
  input  logic [pcmv_pkg::ADDR_W-1:0]         sample_addr_i,
  input  logic signed [pcmv_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic signed [pcmv_pkg::MIX_W-1:0]   mix_left_i,
  input  logic signed [pcmv_pkg::MIX_W-1:0]   mix_right_i,
  input  logic signed [pcmv_pkg::SEEK_W-1:0]  seek_frame_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pcmv_pkg::MIX_W-1:0]   out_left_o,
  output logic signed [pcmv_pkg::MIX_W-1:0]   out_right_o,
  output logic [pcmv_pkg::POS_W-1:0]          playhead_o,
  output logic                                finished_o
);
  import pcmv_pkg::*;

  cfg_t     cfg;
  pipe_en_t en;
  item_t    item1, item2;

  logic signed [SAMPLE_W-1:0] sample1, sample2;
  logic [GAIN_W-1:0] base_l, base_r, trim1, gain_l, gain_r;

  logic v1_q, v2_q, v3_q, vo_q;
  logic out_free, s3_free, s2_free, s1_free, accept;

  assign cfg_ready_o = 1'b1;

  assign out_free = !vo_q || !out_stall_i;
  assign s3_free  = !v3_q || out_free;
  assign s2_free  = !v2_q || s3_free;
  assign s1_free  = !v1_q || s2_free;
  assign accept   = in_valid_i && s1_free;
  assign in_stall_o = !s1_free;

  assign en.s2 = v1_q && s2_free;
  assign en.s3 = v2_q && s3_free;
  assign en.so = v3_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (s1_free)  v1_q <= accept;
      if (s2_free)  v2_q <= v1_q;
      if (s3_free)  v3_q <= v2_q;
      if (out_free) vo_q <= v3_q;
    end
  end

  assign out_valid_o = vo_q;

  pcmv_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  pcmv_voice u_voice (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .op_i           (op_i),
    .sample_addr_i  (sample_addr_i),
    .sample_value_i (sample_value_i),
    .mix_left_i     (mix_left_i),
    .mix_right_i    (mix_right_i),
    .seek_frame_i   (seek_frame_i),
    .cfg_i          (cfg),
    .item_o         (item1),
    .sample_o       (sample1),
    .base_l_o       (base_l),
    .base_r_o       (base_r),
    .trim_o         (trim1)
  );

  pcmv_gain u_gain (
    .clk_i    (clk_i),
    .en_i     (en.s2),
    .item_i   (item1),
    .sample_i (sample1),
    .base_l_i (base_l),
    .base_r_i (base_r),
    .trim_i   (trim1),
    .item_o   (item2),
    .sample_o (sample2),
    .gain_l_o (gain_l),
    .gain_r_o (gain_r)
  );

  pcmv_mix u_mix (
    .clk_i       (clk_i),
    .en_i        (en),
    .item_i      (item2),
    .sample_i    (sample2),
    .gain_l_i    (gain_l),
    .gain_r_i    (gain_r),
    .out_left_o  (out_left_o),
    .out_right_o (out_right_o),
    .playhead_o  (playhead_o),
    .finished_o  (finished_o)
  );

endmodule

`default_nettype wire

@@ rtl/pcmv_cfg_regs.sv @@
// Configuration registers of the sample voice mixer.
// Depends on pcmv_pkg for register indexes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module pcmv_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_i,
  input  logic [1:0]                  index_i,
  input  logic [pcmv_pkg::CFG_W-1:0]  data_i,
  output pcmv_pkg::cfg_t              cfg_o
);
  import pcmv_pkg::*;

  logic [POS_W-1:0]        count_q;
  logic                    stereo_q;
  logic [GAIN_W-1:0]       trim_q;
  logic signed [PAN_W-1:0] pan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      stereo_q <= 1'b1;
      trim_q   <= UNITY;
      pan_q    <= '0;
    end else if (wr_i) begin
      case (cfg_idx_e'(index_i))
        CFG_COUNT:  count_q  <= data_i[POS_W-1:0];
        CFG_STEREO: stereo_q <= data_i[0];
        CFG_TRIM:   trim_q   <= data_i[GAIN_W-1:0];
        CFG_PAN:    pan_q    <= data_i[PAN_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    cfg_o.count  = (count_q > DEPTH_CNT) ? DEPTH_CNT : count_q;
    cfg_o.stereo = stereo_q;
    cfg_o.trim   = trim_q;
    cfg_o.pan    = pan_q;
  end

endmodule

`default_nettype wire

@@ rtl/pcmv_voice.sv @@
// Playhead and finished state, sample store and first pipeline stage.
// Depends on pcmv_pkg. Store read data and pan base gains are registered here.
`timescale 1ns / 1ps
`default_nettype none

module pcmv_voice (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [1:0]                        op_i,
  input  logic [pcmv_pkg::ADDR_W-1:0]       sample_addr_i,
  input  logic signed [pcmv_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic signed [pcmv_pkg::MIX_W-1:0] mix_left_i,
  input  logic signed [pcmv_pkg::MIX_W-1:0] mix_right_i,
  input  logic signed [pcmv_pkg::SEEK_W-1:0] seek_frame_i,
  input  pcmv_pkg::cfg_t                    cfg_i,
  output pcmv_pkg::item_t                   item_o,
  output logic signed [pcmv_pkg::SAMPLE_W-1:0] sample_o,
  output logic [pcmv_pkg::GAIN_W-1:0]       base_l_o,
  output logic [pcmv_pkg::GAIN_W-1:0]       base_r_o,
  output logic [pcmv_pkg::GAIN_W-1:0]       trim_o
);
  import pcmv_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [SAMPLE_DEPTH];

  logic [POS_W-1:0] pos_q, pos_d;
  logic             done_q, done_d;
  logic             active;
  op_e              op;

  logic [GAIN_W-1:0] bl, br;
  logic signed [PAN_W-1:0] pan_plus, pan_minus;

  item_t             item_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [GAIN_W-1:0] bl_q, br_q, trim_q;

  assign op     = op_e'(op_i);
  assign active = (op == OP_MIX) && (pos_q < cfg_i.count);

  always_comb begin
    pos_d  = pos_q;
    done_d = done_q;
    case (op)
      OP_MIX: begin
        if (active) pos_d = pos_q + POS_W'(1);
        else        done_d = 1'b1;
      end
      OP_SEEK: begin
        if (seek_frame_i[SEEK_W-1]) begin
          pos_d  = '0;
          done_d = 1'b0;
        end else if (seek_frame_i[SEEK_W-2:0] >= (SEEK_W-1)'(cfg_i.count)) begin
          pos_d  = cfg_i.count;
          done_d = 1'b1;
        end else begin
          pos_d  = seek_frame_i[POS_W-1:0];
          done_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      done_q <= 1'b0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      done_q <= done_d;
    end
  end

  // linear pan law on the base gains
  assign pan_plus  = cfg_i.pan + PAN_W'(signed'({1'b0, UNITY}));
  assign pan_minus = PAN_W'(signed'({1'b0, UNITY})) - cfg_i.pan;

  always_comb begin
    if (cfg_i.pan <= -PAN_W'(signed'({1'b0, UNITY}))) begin
      bl = UNITY;
      br = '0;
    end else if (cfg_i.pan < 0) begin
      bl = UNITY;
      br = pan_plus[GAIN_W-1:0];
    end else if (cfg_i.pan >= PAN_W'(signed'({1'b0, UNITY}))) begin
      bl = '0;
      br = UNITY;
    end else if (cfg_i.pan > 0) begin
      bl = pan_minus[GAIN_W-1:0];
      br = UNITY;
    end else begin
      bl = UNITY;
      br = UNITY;
    end
  end

  // store: write on load, registered read at the playhead
  always_ff @(posedge clk_i) begin
    if (accept_i && (op == OP_LOAD)) mem[sample_addr_i] <= sample_value_i;
    if (accept_i) sample_q <= mem[pos_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q.active <= active;
      item_q.stereo <= cfg_i.stereo;
      item_q.mix_l  <= mix_left_i;
      item_q.mix_r  <= mix_right_i;
      item_q.pos    <= pos_d;
      item_q.done   <= done_d;
      bl_q          <= bl;
      br_q          <= br;
      trim_q        <= cfg_i.trim;
    end
  end

  assign item_o   = item_q;
  assign sample_o = sample_q;
  assign base_l_o = bl_q;
  assign base_r_o = br_q;
  assign trim_o   = trim_q;

endmodule

`default_nettype wire

@@ rtl/pcmv_gain.sv @@
// Second stage: channel gains from base gain times trim, rounded Q1.15.
// Depends on pcmv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcmv_gain (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  pcmv_pkg::item_t                   item_i,
  input  logic signed [pcmv_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [pcmv_pkg::GAIN_W-1:0]       base_l_i,
  input  logic [pcmv_pkg::GAIN_W-1:0]       base_r_i,
  input  logic [pcmv_pkg::GAIN_W-1:0]       trim_i,
  output pcmv_pkg::item_t                   item_o,
  output logic signed [pcmv_pkg::SAMPLE_W-1:0] sample_o,
  output logic [pcmv_pkg::GAIN_W-1:0]       gain_l_o,
  output logic [pcmv_pkg::GAIN_W-1:0]       gain_r_o
);
  import pcmv_pkg::*;

  localparam logic [2*GAIN_W-1:0] HALF = (2*GAIN_W)'(1 << (FRAC_W - 1));

  logic [2*GAIN_W-1:0] prod_l, prod_r;
  logic [GAIN_W-1:0]   gl, gr;

  item_t               item_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [GAIN_W-1:0]   gl_q, gr_q;

  // g * trim stays below 2^31, so the rounded sum cannot overflow
  assign prod_l = (2*GAIN_W)'(base_l_i) * (2*GAIN_W)'(trim_i) + HALF;
  assign prod_r = (2*GAIN_W)'(base_r_i) * (2*GAIN_W)'(trim_i) + HALF;

  always_comb begin
    if (item_i.stereo) begin
      gl = prod_l[FRAC_W +: GAIN_W];
      gr = prod_r[FRAC_W +: GAIN_W];
    end else begin
      gl = trim_i;
      gr = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q   <= item_i;
      sample_q <= sample_i;
      gl_q     <= gl;
      gr_q     <= gr;
    end
  end

  assign item_o   = item_q;
  assign sample_o = sample_q;
  assign gain_l_o = gl_q;
  assign gain_r_o = gr_q;

endmodule

`default_nettype wire

@@ rtl/pcmv_mix.sv @@
// Third and output stages: sample times gain, then round, add and saturate.
// Depends on pcmv_pkg; holds the result registers seen on the output ports.
`timescale 1ns / 1ps
`default_nettype none

module pcmv_mix (
  input  logic                              clk_i,
  input  pcmv_pkg::pipe_en_t                en_i,
  input  pcmv_pkg::item_t                   item_i,
  input  logic signed [pcmv_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [pcmv_pkg::GAIN_W-1:0]       gain_l_i,
  input  logic [pcmv_pkg::GAIN_W-1:0]       gain_r_i,
  output logic signed [pcmv_pkg::MIX_W-1:0] out_left_o,
  output logic signed [pcmv_pkg::MIX_W-1:0] out_right_o,
  output logic [pcmv_pkg::POS_W-1:0]        playhead_o,
  output logic                              finished_o
);
  import pcmv_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1 << (FRAC_W - 1));

  item_t                    item_q;
  logic signed [PROD_W-1:0] prod_l_q, prod_r_q;

  logic signed [PROD_W-1:0]  rnd_l, rnd_r;
  logic signed [SCALE_W-1:0] sc_l, sc_r;
  logic signed [MIX_W-1:0]   sat_l, sat_r;
  logic signed [MIX_W-1:0]   left_d, right_d;

  logic signed [MIX_W-1:0] out_left_q, out_right_q;
  logic [POS_W-1:0]        playhead_q;
  logic                    finished_q;

  function automatic logic signed [MIX_W-1:0] sat_add(
    input logic signed [MIX_W-1:0]   mix,
    input logic signed [SCALE_W-1:0] sc
  );
    logic signed [MIX_W:0] sum;
    sum = {mix[MIX_W-1], mix} + {{(MIX_W + 1 - SCALE_W){sc[SCALE_W-1]}}, sc};
    if (sum[MIX_W] != sum[MIX_W-1])
      sat_add = sum[MIX_W] ? {1'b1, {(MIX_W-1){1'b0}}} : {1'b0, {(MIX_W-1){1'b1}}};
    else
      sat_add = sum[MIX_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      item_q   <= item_i;
      prod_l_q <= PROD_W'(sample_i) * PROD_W'(signed'({1'b0, gain_l_i}));
      prod_r_q <= PROD_W'(sample_i) * PROD_W'(signed'({1'b0, gain_r_i}));
    end
  end

  // arithmetic shift after the half bias rounds half toward plus infinity
  assign rnd_l = prod_l_q + HALF;
  assign rnd_r = prod_r_q + HALF;
  assign sc_l  = rnd_l[PROD_W-1:FRAC_W];
  assign sc_r  = rnd_r[PROD_W-1:FRAC_W];
  assign sat_l = sat_add(item_q.mix_l, sc_l);
  assign sat_r = sat_add(item_q.mix_r, sc_r);

  assign left_d  = item_q.active ? sat_l : item_q.mix_l;
  assign right_d = (item_q.active && item_q.stereo) ? sat_r : item_q.mix_r;

  always_ff @(posedge clk_i) begin
    if (en_i.so) begin
      out_left_q  <= left_d;
      out_right_q <= right_d;
      playhead_q  <= item_q.pos;
      finished_q  <= item_q.done;
    end
  end

  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;
  assign playhead_o  = playhead_q;
  assign finished_o  = finished_q;

endmodule

`default_nettype wire

@@ rtl/pcmv_checker.sv @@
// Port-level checks for the sample voice mixer, bound to the top level.
// Depends on pcmv_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module pcmv_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_stall_o,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic signed [pcmv_pkg::MIX_W-1:0]   out_left_o,
  input  logic signed [pcmv_pkg::MIX_W-1:0]   out_right_o,
  input  logic [pcmv_pkg::POS_W-1:0]          playhead_o,
  input  logic                                finished_o
);
  import pcmv_pkg::*;

  // back-pressure on the input only ever comes from a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // playhead is clamped to the store depth
  a_playhead_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (playhead_o <= DEPTH_CNT))
    else $error("playhead beyond store depth");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_left_o)
      && $stable(out_right_o) && $stable(playhead_o) && $stable(finished_o)))
    else $error("stalled result changed");

  // the pipe holds four items, so the input may only stall once it is full
  a_no_early_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no result waiting");

endmodule

bind pcm_voice_gain_pan_mixer pcmv_checker u_pcmv_checker (.*);

`default_nettype wire

@@ tb/pcm_voice_gain_pan_mixer_test.sv @@
// Self-checking bench for the sample voice mixer: directed table, then random phases
// under several register settings, items checked against a voice model or their row.
// Depends on pcmv_pkg and pcm_voice_gain_pan_mixer.
`timescale 1ns / 1ps

module pcm_voice_gain_pan_mixer_test;
  import pcmv_pkg::*;

  localparam int MIX_MAX       = (1 << (MIX_W - 1)) - 1;
  localparam int MIX_MIN       = -MIX_MAX - 1;
  localparam int SAMPLE_MAX    = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SAMPLE_MIN    = -SAMPLE_MAX - 1;
  localparam int SEEK_MAX      = (1 << (SEEK_W - 1)) - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 100;
  localparam int TIMEOUT_NS    = 2_000_000;

  typedef struct {
    op_e                        op;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] value;
    logic signed [MIX_W-1:0]    ml;
    logic signed [MIX_W-1:0]    mr;
    logic signed [SEEK_W-1:0]   seek;
  } cmd_t;

  typedef struct {
    logic signed [MIX_W-1:0] l;
    logic signed [MIX_W-1:0] r;
    logic [POS_W-1:0]        ph;
    logic                    fin;
  } frame_t;

  typedef struct {
    bit               is_cfg;
    cfg_idx_e         idx;
    logic [CFG_W-1:0] data;
    cmd_t             cmd;
    bit               typed;
    frame_t           want;
  } row_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 op = '0;
  logic [ADDR_W-1:0]          sample_addr = '0;
  logic signed [SAMPLE_W-1:0] sample_value = '0;
  logic signed [MIX_W-1:0]    mix_left = '0;
  logic signed [MIX_W-1:0]    mix_right = '0;
  logic signed [SEEK_W-1:0]   seek_frame = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [MIX_W-1:0]    out_left;
  logic signed [MIX_W-1:0]    out_right;
  logic [POS_W-1:0]           playhead;
  logic                       finished;

  int send_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  frame_t pending_frames[$];

  // voice model state and its copy of the registers
  logic signed [SAMPLE_W-1:0] vstore [SAMPLE_DEPTH];
  bit                         vwritten [SAMPLE_DEPTH];
  logic [POS_W-1:0]           vpos = '0;
  logic                       vdone = 1'b0;
  logic [POS_W-1:0]           c_count = '0;
  logic                       c_stereo = 1'b1;
  logic [GAIN_W-1:0]          c_trim = UNITY;
  logic signed [PAN_W-1:0]    c_pan = '0;

  pcm_voice_gain_pan_mixer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .sample_addr_i  (sample_addr),
    .sample_value_i (sample_value),
    .mix_left_i     (mix_left),
    .mix_right_i    (mix_right),
    .seek_frame_i   (seek_frame),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_left_o     (out_left),
    .out_right_o    (out_right),
    .playhead_o     (playhead),
    .finished_o     (finished)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL pcm_voice_gain_pan_mixer");
    $finish;
  end

  function automatic int live_count();
    return (c_count > SAMPLE_DEPTH) ? SAMPLE_DEPTH : int'(c_count);
  endfunction

  function automatic logic [MIX_W-1:0] sat_mix(longint v);
    if (v > MIX_MAX) v = MIX_MAX;
    if (v < MIX_MIN) v = MIX_MIN;
    return v[MIX_W-1:0];
  endfunction

  // Q1.15 product, rounding half up
  function automatic longint apply_gain(longint s, longint g);
    return (s * g + 64'sd16384) >>> 15;
  endfunction

  function automatic longint trim_gain(longint base);
    longint t;
    t = c_trim;
    return (base * t + 64'sd16384) >>> 15;
  endfunction

  function automatic frame_t voice_step(cmd_t c);
    frame_t fr;
    longint ml, mr, s, p, bl, br, gl, gr, f;
    int cnt;
    cnt = live_count();
    ml = c.ml;
    mr = c.mr;
    fr.l = sat_mix(ml);
    fr.r = sat_mix(mr);
    case (c.op)
      OP_LOAD: begin
        vstore[c.addr] = c.value;
        vwritten[c.addr] = 1'b1;
      end
      OP_MIX: begin
        if (vpos >= cnt) begin
          vdone = 1'b1;
        end else begin
          s = vstore[vpos[ADDR_W-1:0]];
          if (!c_stereo) begin
            gl = c_trim;
            gr = 0;
          end else begin
            p = c_pan;
            if (p <= -32768) begin
              bl = 32768; br = 0;
            end else if (p < 0) begin
              bl = 32768; br = p + 32768;
            end else if (p >= 32768) begin
              bl = 0; br = 32768;
            end else if (p > 0) begin
              bl = 32768 - p; br = 32768;
            end else begin
              bl = 32768; br = 32768;
            end
            gl = trim_gain(bl);
            gr = trim_gain(br);
          end
          fr.l = sat_mix(ml + apply_gain(s, gl));
          if (c_stereo) fr.r = sat_mix(mr + apply_gain(s, gr));
          vpos = vpos + POS_W'(1);
        end
      end
      OP_SEEK: begin
        f = c.seek;
        if (f < 0) begin
          vpos = '0;
          vdone = 1'b0;
        end else if (f >= cnt) begin
          vpos = POS_W'(cnt);
          vdone = 1'b1;
        end else begin
          vpos = f[POS_W-1:0];
          vdone = 1'b0;
        end
      end
      default: ;
    endcase
    fr.ph = vpos;
    fr.fin = vdone;
    return fr;
  endfunction

  function automatic logic [MIX_W-1:0] pick_mix();
    case ($urandom_range(7))
      0: return MIX_MAX[MIX_W-1:0];
      1: return MIX_MIN[MIX_W-1:0];
      default: return MIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MAX[SAMPLE_W-1:0];
      1: return SAMPLE_MIN[SAMPLE_W-1:0];
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int cnt;
    int r;
    cnt = live_count();
    c.addr = ADDR_W'($urandom);
    c.value = pick_sample();
    c.ml = pick_mix();
    c.mr = pick_mix();
    c.seek = SEEK_W'($urandom);
    r = $urandom_range(99);
    if (r < 50) c.op = OP_MIX;
    else if (r < 72) c.op = OP_LOAD;
    else if (r < 88) c.op = OP_SEEK;
    else c.op = OP_NOP;
    if (c.op == OP_LOAD) begin
      case ($urandom_range(3))
        0, 1: c.addr = ADDR_W'(vpos + $urandom_range(3));
        2: if (cnt > 0) c.addr = ADDR_W'($urandom_range(cnt - 1));
        default: ;
      endcase
    end
    if (c.op == OP_SEEK) begin
      case ($urandom_range(5))
        0, 1: c.seek = SEEK_W'($urandom_range(cnt + 2));
        2: c.seek = SEEK_W'(0 - $urandom_range(40, 1));
        3: c.seek = SEEK_W'(cnt);
        default: ;
      endcase
    end
    // never play an entry that holds no sample yet: load it instead
    if (c.op == OP_MIX && vpos < cnt && !vwritten[vpos[ADDR_W-1:0]]) begin
      c.op = OP_LOAD;
      c.addr = vpos[ADDR_W-1:0];
    end
    return c;
  endfunction

  function automatic row_t cmd_row(op_e o, int addr, int value, int ml, int mr, int seek);
    row_t r;
    r.is_cfg = 1'b0;
    r.idx = CFG_COUNT;
    r.data = '0;
    r.cmd.op = o;
    r.cmd.addr = addr[ADDR_W-1:0];
    r.cmd.value = value[SAMPLE_W-1:0];
    r.cmd.ml = ml[MIX_W-1:0];
    r.cmd.mr = mr[MIX_W-1:0];
    r.cmd.seek = seek[SEEK_W-1:0];
    r.typed = 1'b0;
    r.want.l = '0;
    r.want.r = '0;
    r.want.ph = '0;
    r.want.fin = 1'b0;
    return r;
  endfunction

  function automatic row_t cfg_row(cfg_idx_e idx, int data);
    row_t r;
    r = cmd_row(OP_NOP, 0, 0, 0, 0, 0);
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data[CFG_W-1:0];
    return r;
  endfunction

  function automatic row_t typed_row(row_t r, int l, int rr, int ph, int fin);
    r.typed = 1'b1;
    r.want.l = l[MIX_W-1:0];
    r.want.r = rr[MIX_W-1:0];
    r.want.ph = ph[POS_W-1:0];
    r.want.fin = fin[0];
    return r;
  endfunction

  task automatic send_cmd(cmd_t c, bit typed, frame_t want);
    frame_t fr;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= c.op;
    sample_addr  <= c.addr;
    sample_value <= c.value;
    mix_left     <= c.ml;
    mix_right    <= c.mr;
    seek_frame   <= c.seek;
    do @(posedge clk); while (in_stall);
    fr = voice_step(c);
    pending_frames.push_back(typed ? want : fr);
  endtask

  // registers change only with the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COUNT:  c_count = data[POS_W-1:0];
      CFG_STEREO: c_stereo = data[0];
      CFG_TRIM:   c_trim = data[GAIN_W-1:0];
      CFG_PAN:    c_pan = data[PAN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic phase_config(int p);
    int counts [8] = '{16, 0, 4096, 8191, 40, 1, 300, 4095};
    int stereos [8] = '{1, 1, 0, 1, 1, 0, 1, 1};
    int trims [8] = '{32768, 0, 65535, 32768, 12345, 65535, 40000, 32768};
    int pans [8] = '{-65536, -32768, 0, 65535, 32768, -1, 1, 32767};
    int cnt_v, st_v, trim_v, pan_v;
    if (p < 8) begin
      cnt_v = counts[p];
      st_v = stereos[p];
      trim_v = trims[p];
      pan_v = pans[p];
    end else begin
      cnt_v = (p == 8) ? int'($urandom) : int'($urandom_range(64));
      st_v = int'($urandom_range(1));
      trim_v = int'($urandom_range(65535));
      pan_v = int'($urandom);
    end
    write_reg(CFG_COUNT, cnt_v[CFG_W-1:0]);
    write_reg(CFG_STEREO, st_v[CFG_W-1:0]);
    write_reg(CFG_TRIM, trim_v[CFG_W-1:0]);
    write_reg(CFG_PAN, pan_v[CFG_W-1:0]);
  endtask

  always @(posedge clk) begin : result_check
    frame_t got;
    frame_t w;
    if (rst_n && out_valid && !out_stall) begin
      got.l = out_left;
      got.r = out_right;
      got.ph = playhead;
      got.fin = finished;
      if (pending_frames.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: l %0d r %0d ph %0d fin %0d",
                   got.l, got.r, got.ph, got.fin);
        mismatches++;
      end else begin
        w = pending_frames.pop_front();
        if (got.l !== w.l || got.r !== w.r || got.ph !== w.ph || got.fin !== w.fin) begin
          if (mismatches < 10)
            $display({"mismatch: exp l %0d r %0d ph %0d fin %0d, ",
                      "got l %0d r %0d ph %0d fin %0d"},
                     w.l, w.r, w.ph, w.fin, got.l, got.r, got.ph, got.fin);
          mismatches++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin : stimulus
    row_t rows[$];
    cmd_t c;
    frame_t none;
    none.l = '0;
    none.r = '0;
    none.ph = '0;
    none.fin = 1'b0;

    // after reset: count 0, so a mix only sets finished
    rows.push_back(typed_row(cmd_row(OP_MIX, 0, 0, MIX_MAX, MIX_MIN, 0),
                             MIX_MAX, MIX_MIN, 0, 1));
    rows.push_back(typed_row(cmd_row(OP_SEEK, 0, 0, 1, -1, -1), 1, -1, 0, 0));
    rows.push_back(typed_row(cmd_row(OP_NOP, 4095, SAMPLE_MIN, 0, 0, SEEK_MAX), 0, 0, 0, 0));
    rows.push_back(typed_row(cmd_row(OP_LOAD, 0, SAMPLE_MAX, -1, 1, 0), -1, 1, 0, 0));
    rows.push_back(typed_row(cmd_row(OP_LOAD, 1, SAMPLE_MIN, MIX_MIN, MIX_MAX, 0),
                             MIX_MIN, MIX_MAX, 0, 0));
    rows.push_back(typed_row(cmd_row(OP_LOAD, 2, 1, 0, 0, 0), 0, 0, 0, 0));
    rows.push_back(typed_row(cmd_row(OP_LOAD, 4095, -1, 0, 0, 0), 0, 0, 0, 0));
    rows.push_back(cfg_row(CFG_COUNT, 4096));
    rows.push_back(typed_row(cmd_row(OP_SEEK, 0, 0, 0, 0, SEEK_MAX), 0, 0, 4096, 1));
    // count above the depth acts as the depth
    rows.push_back(cfg_row(CFG_COUNT, 'h1FFFF));
    rows.push_back(typed_row(cmd_row(OP_SEEK, 0, 0, 0, 0, 4095), 0, 0, 4095, 0));
    rows.push_back(cmd_row(OP_MIX, 0, 0, 0, 0, 0));
    rows.push_back(typed_row(cmd_row(OP_MIX, 0, 0, 5, -5, 0), 5, -5, 4096, 1));
    rows.push_back(cfg_row(CFG_COUNT, 3));
    rows.push_back(typed_row(cmd_row(OP_SEEK, 0, 0, 0, 0, 0), 0, 0, 0, 0));
    rows.push_back(cmd_row(OP_MIX, 0, 0, MIX_MAX, MIX_MIN, 0));
    rows.push_back(cmd_row(OP_MIX, 0, 0, MIX_MIN, MIX_MAX, 0));
    rows.push_back(cmd_row(OP_MIX, 0, 0, 100, -100, 0));
    rows.push_back(typed_row(cmd_row(OP_MIX, 0, 0, 7, 8, 0), 7, 8, 3, 1));
    rows.push_back(cfg_row(CFG_STEREO, 0));
    rows.push_back(cfg_row(CFG_TRIM, 65535));
    rows.push_back(typed_row(cmd_row(OP_SEEK, 0, 0, 0, 0, 0), 0, 0, 0, 0));
    rows.push_back(cmd_row(OP_MIX, 0, 0, -3, 1234, 0));
    rows.push_back(cfg_row(CFG_PAN, -65536));
    rows.push_back(cfg_row(CFG_STEREO, 1));
    rows.push_back(cmd_row(OP_MIX, 0, 0, 0, 0, 0));
    rows.push_back(cfg_row(CFG_PAN, 32768));
    rows.push_back(cmd_row(OP_MIX, 0, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        settle();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_cmd(rows[i].cmd, rows[i].typed, rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      phase_config(p);
      case (p % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 55; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 55; end
        default: begin send_pct = 15; stall_pct = 15; end
      endcase
      repeat (PHASE_ITEMS) begin
        c = random_cmd();
        send_cmd(c, 1'b0, none);
      end
    end

    stall_pct = 0;
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("PASS pcm_voice_gain_pan_mixer");
    end else begin
      $display("FAIL pcm_voice_gain_pan_mixer");
    end
    $finish;
  end

endmodule
